@@ src/dssfd_pkg.sv @@
// Shared types and constants for the decimal seven-segment frame driver.
// Self-contained; used by the top level.
`default_nettype none

package dssfd_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIRST_DIGIT  = 2'd0,
		REG_LAST_DIGIT   = 2'd1,
		REG_POINT_OFFSET = 2'd2,
		REG_POINT_ENABLE = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [2:0] FIRST_DIGIT_RST  = 3'd0;
	localparam logic [2:0] LAST_DIGIT_RST   = 3'd7;
	localparam logic [2:0] POINT_OFFSET_RST = 3'd0;

	// Reciprocal of ten: q = (x * RECIP10) >> RECIP10_SHIFT, exact for 32-bit x
	localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
	localparam int unsigned RECIP10_SHIFT = 35;

	localparam logic [7:0] SEG_POINT = 8'h80;

	// One frame token between the sequencer and the digit stage
	typedef struct packed {
		logic [3:0] rem_lo;   // low bits of the value being split
		logic [3:0] quo_lo;   // low bits of its quotient by ten
		logic [2:0] pos;
		logic       point;
		logic       last;
	} frame_tok_t;

	// Seven-segment pattern for a decimal digit, segments a..g in bits 0..6
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0:    seg = 8'h3f;
			4'd1:    seg = 8'h06;
			4'd2:    seg = 8'h5b;
			4'd3:    seg = 8'h4f;
			4'd4:    seg = 8'h66;
			4'd5:    seg = 8'h6d;
			4'd6:    seg = 8'h7d;
			4'd7:    seg = 8'h07;
			4'd8:    seg = 8'h7f;
			4'd9:    seg = 8'h6f;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

@@ src/decimal_seven_segment_frame_driver.sv @@
// Top level of the decimal seven-segment frame driver: config registers,
// digit sequencer and frame pipeline. Depends on dssfd_pkg.
//
//   channel  dir   handshake              payload
//   input    in    in_valid / in_ready    value
//   output   out   out_valid / out_ready  digit_select, segments, position, last
//   config   in    cfg_we                 cfg_index, cfg_data
//
// One value gives last_digit - first_digit + 1 frames, one per cycle unless
// out_ready stalls; the digit sequencer does one multiply by the reciprocal
// of ten per frame. A new value is taken in the cycle the previous value's
// last frame leaves the sequencer.
// Frames then pass two more register stages.
// Reset clears all valid bits and the config registers to their defaults.
// A stall on out_ready backs up through the stages; nothing is lost or repeated.
// An empty range (first_digit > last_digit) takes the value and gives no frame.
`default_nettype none

module decimal_seven_segment_frame_driver #(
	parameter int unsigned NUM_DIGITS  = 8,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// config write port
	input  wire logic                               cfg_we,
	input  wire logic [dssfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [dssfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [VALUE_WIDTH-1:0]             value,
	// output channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              digit_select,
	output logic [7:0]                              segments,
	output logic [2:0]                              position,
	output logic                                    last
);

	localparam logic [2:0] TOP_POS = 3'(NUM_DIGITS - 1);
	localparam int unsigned PROD_W = VALUE_WIDTH + 32;

	// Config registers
	logic [2:0] first_digit_q;
	logic [2:0] last_digit_q;
	logic [2:0] point_offset_q;
	logic       point_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_digit_q  <= dssfd_pkg::FIRST_DIGIT_RST;
			last_digit_q   <= dssfd_pkg::LAST_DIGIT_RST;
			point_offset_q <= dssfd_pkg::POINT_OFFSET_RST;
			point_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (dssfd_pkg::cfg_reg_t'(cfg_index))
				dssfd_pkg::REG_FIRST_DIGIT:  first_digit_q  <= cfg_data;
				dssfd_pkg::REG_LAST_DIGIT:   last_digit_q   <= cfg_data;
				dssfd_pkg::REG_POINT_OFFSET: point_offset_q <= cfg_data;
				dssfd_pkg::REG_POINT_ENABLE: point_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamped range and point position
	logic [2:0] lo_pos, hi_pos, point_pos;
	logic       has_point, empty_range;

	always_comb begin
		lo_pos      = (first_digit_q > TOP_POS) ? TOP_POS : first_digit_q;
		hi_pos      = (last_digit_q > TOP_POS) ? TOP_POS : last_digit_q;
		has_point   = point_enable_q && (point_offset_q <= hi_pos);
		point_pos   = hi_pos - point_offset_q;
		empty_range = lo_pos > hi_pos;
	end

	// Stage handshakes
	logic                   valid_s1, valid_s2, valid_s3;
	logic                   ready_s2, ready_s3;
	logic                   adv_s1, last_s1;
	logic [VALUE_WIDTH-1:0] rem_s1;
	logic [2:0]             pos_s1;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign adv_s1   = valid_s1 && ready_s2;
	assign last_s1  = pos_s1 == lo_pos;
	assign in_ready = !valid_s1 || (adv_s1 && last_s1);

	// Stage 1: digit sequencer, one division by ten per frame
	logic [PROD_W-1:0]      prod;
	logic [VALUE_WIDTH-1:0] quo;

	always_comb begin
		prod = PROD_W'(rem_s1) * PROD_W'(dssfd_pkg::RECIP10);
		quo  = VALUE_WIDTH'(prod >> dssfd_pkg::RECIP10_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= !empty_range;
		end else if (adv_s1 && last_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s1 <= value;
			pos_s1 <= hi_pos;
		end else if (adv_s1) begin
			rem_s1 <= quo;
			pos_s1 <= pos_s1 - 3'd1;
		end
	end

	// Stage 2: frame token
	dssfd_pkg::frame_tok_t tok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tok_s2.rem_lo <= rem_s1[3:0];
			tok_s2.quo_lo <= quo[3:0];
			tok_s2.pos    <= pos_s1;
			tok_s2.point  <= has_point && (pos_s1 == point_pos);
			tok_s2.last   <= last_s1;
		end
	end

	// Stage 3: digit, segment lookup and select byte
	logic [3:0] digit_s2;
	logic [7:0] seg_s2;
	logic [7:0] digit_select_s3, segments_s3;
	logic [2:0] position_s3;
	logic       last_s3;

	always_comb begin
		// remainder is below ten, so four low bits are enough
		digit_s2 = tok_s2.rem_lo - 4'(tok_s2.quo_lo * 4'd10);
		seg_s2   = dssfd_pkg::seg_pattern(digit_s2);
		if (tok_s2.point) begin
			seg_s2 = seg_s2 | dssfd_pkg::SEG_POINT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			digit_select_s3 <= ~(8'd1 << tok_s2.pos);
			segments_s3     <= seg_s2;
			position_s3     <= tok_s2.pos;
			last_s3         <= tok_s2.last;
		end
	end

	assign out_valid    = valid_s3;
	assign digit_select = digit_select_s3;
	assign segments     = segments_s3;
	assign position     = position_s3;
	assign last         = last_s3;

endmodule

`default_nettype wire

@@ src/dssfd_checker.sv @@
// Port-level checks for the decimal seven-segment frame driver, bound to
// the top level. Depends on nothing beyond the top level's ports.
`default_nettype none

module dssfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] digit_select,
	input wire logic [7:0] segments,
	input wire logic [2:0] position,
	input wire logic       last
);

	// Select byte is the one-cold code of the position
	a_select_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_select == ~(8'd1 << position))
		else $error("digit_select does not match position");

	// Position zero is always the end of a run
	a_pos0_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position == 3'd0 |-> last)
		else $error("frame at position zero not marked last");

	// Every frame shows a digit
	a_seg_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> segments[6:0] != 7'd0)
		else $error("frame with blank segment pattern");

	// A stalled frame stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segments) && $stable(position)
			&& $stable(last))
		else $error("stalled frame changed");

endmodule

bind decimal_seven_segment_frame_driver dssfd_checker u_dssfd_checker (.*);

`default_nettype wire
